### hdl/ising_greedy_spin_flip_assert.svh
// Assertion macros used by the checker file of the spin-flip engine.
`ifndef ISING_GREEDY_SPIN_FLIP_ASSERT_SVH
`define ISING_GREEDY_SPIN_FLIP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define IGSF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("igsf: same-cycle property failed");

// Consequent must hold in the cycle after the antecedent.
`define IGSF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("igsf: next-cycle property failed");

`endif

### hdl/igsf_pkg.sv
`default_nettype none

package igsf_pkg;

  // Fixed field widths of the request and response.
  localparam int MODE_W   = 2;
  localparam int IDX_IN_W = 10;
  localparam int CPL_IN_W = 16;
  localparam int ENERGY_W = 40;
  localparam int FIELD_W  = 32;

  // Default sizing.
  localparam int SITES_DEF         = 256;
  localparam int COUPLING_BITS_DEF = 16;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD = 2'd0,
    MODE_SET  = 2'd1,
    MODE_EVAL = 2'd2,
    MODE_FLIP = 2'd3
  } mode_e;

  typedef struct packed {
    logic [MODE_W-1:0]          mode;
    logic [IDX_IN_W-1:0]        row_index;
    logic [IDX_IN_W-1:0]        col_index;
    logic signed [CPL_IN_W-1:0] coupling_value;
    logic [IDX_IN_W-1:0]        site_index;
    logic                       spin_value;
  } req_t;

  typedef struct packed {
    logic signed [ENERGY_W-1:0] energy;
    logic signed [FIELD_W-1:0]  local_field;
    logic                       flipped;
  } rsp_t;

  // Controller to datapath.
  typedef struct packed {
    logic clr;
    logic take;
    logic wr_cpl;
    logic wr_spin;
    logic rd_site;
    logic sweep;
    logic finish;
    logic update;
    logic reply;
  } ctl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    mode_e mode;
    logic  site_ok;
    logic  clr_last;
    logic  sweep_last;
    logic  pipe_busy;
    logic  out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

### hdl/igsf_ctrl.sv
`default_nettype none

module igsf_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  igsf_pkg::dp_sts_t  sts_i,
  output igsf_pkg::ctl_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISPATCH,
    ST_SWEEP,
    ST_DRAIN,
    ST_FINISH,
    ST_UPDATE,
    ST_REPLY
  } state_e;

  state_e state_q, state_d;
  logic   stall_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (sts_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        unique case (sts_i.mode)
          igsf_pkg::MODE_LOAD: begin
            cmd_o.wr_cpl = 1'b1;
            state_d      = ST_REPLY;
          end
          igsf_pkg::MODE_SET: begin
            cmd_o.wr_spin = 1'b1;
            state_d       = ST_REPLY;
          end
          igsf_pkg::MODE_EVAL: begin
            state_d = ST_SWEEP;
          end
          igsf_pkg::MODE_FLIP: begin
            if (sts_i.site_ok) begin
              cmd_o.rd_site = 1'b1;
              state_d       = ST_SWEEP;
            end else begin
              state_d = ST_REPLY;
            end
          end
        endcase
      end
      ST_SWEEP: begin
        cmd_o.sweep = 1'b1;
        if (sts_i.sweep_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!sts_i.pipe_busy) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        cmd_o.finish = 1'b1;
        if (sts_i.mode == igsf_pkg::MODE_FLIP) begin
          state_d = ST_UPDATE;
        end else begin
          state_d = ST_REPLY;
        end
      end
      ST_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = ST_REPLY;
      end
      ST_REPLY: begin
        if (sts_i.out_free) begin
          cmd_o.reply = 1'b1;
          state_d     = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      stall_q <= 1'b1;
    end else begin
      state_q <= state_d;
      stall_q <= (state_d != ST_IDLE);
    end
  end

  assign in_stall_o = stall_q;

endmodule

`default_nettype wire

### hdl/igsf_dp.sv
`default_nettype none

module igsf_dp #(
  parameter int SITES         = igsf_pkg::SITES_DEF,
  parameter int COUPLING_BITS = igsf_pkg::COUPLING_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  igsf_pkg::req_t     in_req_i,
  input  logic               out_stall_i,
  input  igsf_pkg::ctl_cmd_t cmd_i,
  output igsf_pkg::dp_sts_t  sts_o,
  output logic               out_valid_o,
  output igsf_pkg::rsp_t     out_rsp_o
);

  localparam int IDX_W  = $clog2(SITES);
  localparam int ADDR_W = 2 * IDX_W;
  localparam int ACC_W  = COUPLING_BITS + ADDR_W + 1;
  localparam int CIN_W  = (COUPLING_BITS > igsf_pkg::CPL_IN_W) ? COUPLING_BITS
                                                               : igsf_pkg::CPL_IN_W;
  localparam int EW_W   = (ACC_W > igsf_pkg::ENERGY_W) ? ACC_W : igsf_pkg::ENERGY_W;
  localparam int FW_W   = (ACC_W > igsf_pkg::FIELD_W) ? ACC_W : igsf_pkg::FIELD_W;
  localparam int UPD_W  = igsf_pkg::ENERGY_W + 1;
  localparam int RNG_W  = igsf_pkg::IDX_IN_W + 1;

  localparam logic [IDX_W-1:0] LAST     = IDX_W'(SITES - 1);
  localparam logic [RNG_W-1:0] SITES_X  = RNG_W'(SITES);
  localparam logic [COUPLING_BITS-1:0] CPL_MAX = {1'b0, {(COUPLING_BITS-1){1'b1}}};
  localparam logic [COUPLING_BITS-1:0] CPL_MIN = {1'b1, {(COUPLING_BITS-1){1'b0}}};
  localparam logic [igsf_pkg::ENERGY_W-1:0] E_MAX = {1'b0, {(igsf_pkg::ENERGY_W-1){1'b1}}};
  localparam logic [igsf_pkg::ENERGY_W-1:0] E_MIN = {1'b1, {(igsf_pkg::ENERGY_W-1){1'b0}}};
  localparam logic [igsf_pkg::FIELD_W-1:0]  F_MAX = {1'b0, {(igsf_pkg::FIELD_W-1){1'b1}}};
  localparam logic [igsf_pkg::FIELD_W-1:0]  F_MIN = {1'b1, {(igsf_pkg::FIELD_W-1){1'b0}}};

  igsf_pkg::req_t req_q;

  // Request decode
  logic             is_eval;
  logic             site_ok, pair_ok;
  logic [IDX_W-1:0] site, row_r, col_r, pair_a, pair_b;

  assign is_eval = (req_q.mode == igsf_pkg::MODE_EVAL);
  assign site_ok = ({1'b0, req_q.site_index} < SITES_X);
  assign pair_ok = ({1'b0, req_q.row_index} < SITES_X) && ({1'b0, req_q.col_index} < SITES_X);
  assign site    = req_q.site_index[IDX_W-1:0];
  assign row_r   = req_q.row_index[IDX_W-1:0];
  assign col_r   = req_q.col_index[IDX_W-1:0];
  assign pair_a  = (row_r <= col_r) ? row_r : col_r;
  assign pair_b  = (row_r <= col_r) ? col_r : row_r;

  // Coupling written to the store saturates to its width.
  logic signed [CIN_W-1:0]         cin_x;
  logic [CIN_W-COUPLING_BITS:0]    cin_hi;
  logic [COUPLING_BITS-1:0]        cpl_sat;

  always_comb begin
    cin_x   = CIN_W'(signed'(req_q.coupling_value));
    cin_hi  = cin_x[CIN_W-1:COUPLING_BITS-1];
    if ((&cin_hi) || !(|cin_hi)) begin
      cpl_sat = cin_x[COUPLING_BITS-1:0];
    end else begin
      cpl_sat = cin_x[CIN_W-1] ? CPL_MIN : CPL_MAX;
    end
  end

  // Sweep counters and clearing counter
  logic [IDX_W-1:0]  i_q, j_q;
  logic [ADDR_W-1:0] clr_q;
  logic [IDX_W-1:0]  sw_row, sw_col;

  assign sw_row = is_eval ? i_q : ((j_q < site) ? j_q : site);
  assign sw_col = is_eval ? j_q : ((j_q < site) ? site : j_q);

  // Memories
  logic signed [COUPLING_BITS-1:0] cpl_mem [0:(1<<ADDR_W)-1];
  logic                            spin_mem [0:(1<<IDX_W)-1];
  logic signed [COUPLING_BITS-1:0] cpl_rd_q;
  logic                            spin_rd_q;

  logic                     cpl_we, spin_we, spin_wd;
  logic [ADDR_W-1:0]        cpl_wa, cpl_ra;
  logic [COUPLING_BITS-1:0] cpl_wd;
  logic [IDX_W-1:0]         spin_wa, spin_ra;
  logic                     si_q;
  logic                     flip_ok;

  always_comb begin
    cpl_we  = cmd_i.clr || (cmd_i.wr_cpl && pair_ok);
    cpl_wa  = cmd_i.clr ? clr_q : {pair_a, pair_b};
    cpl_wd  = cmd_i.clr ? '0 : cpl_sat;
    cpl_ra  = {sw_row, sw_col};
    spin_we = cmd_i.clr || (cmd_i.wr_spin && site_ok) || (cmd_i.update && flip_ok);
    spin_wa = cmd_i.clr ? clr_q[IDX_W-1:0] : site;
    if (cmd_i.clr) begin
      spin_wd = 1'b0;
    end else if (cmd_i.wr_spin) begin
      spin_wd = req_q.spin_value;
    end else begin
      spin_wd = ~si_q;
    end
    spin_ra = cmd_i.rd_site ? site : j_q;
  end

  always_ff @(posedge clk_i) begin
    if (cpl_we) begin
      cpl_mem[cpl_wa] <= cpl_wd;
    end
    cpl_rd_q <= cpl_mem[cpl_ra];
  end

  always_ff @(posedge clk_i) begin
    if (spin_we) begin
      spin_mem[spin_wa] <= spin_wd;
    end
    spin_rd_q <= spin_mem[spin_ra];
  end

  // Term formation: the registered coupling read, signed by the spins.
  logic                    p1_v_q, p1_diag_q, p1_self_q, site_rd_q;
  logic signed [ACC_W-1:0] acc_q, cpl_x, term;
  logic                    neg;

  always_comb begin
    cpl_x = ACC_W'(signed'(cpl_rd_q));
    neg   = is_eval ? (!p1_diag_q && (si_q ^ spin_rd_q)) : spin_rd_q;
    if (p1_self_q) begin
      term = '0;
    end else begin
      term = neg ? -cpl_x : cpl_x;
    end
  end

  // Saturation of the sum to energy and field ranges, and the flip update.
  logic signed [EW_W-1:0]              acc_e;
  logic [EW_W-igsf_pkg::ENERGY_W:0]    acc_e_hi;
  logic [igsf_pkg::ENERGY_W-1:0]       sat_e;
  logic signed [FW_W-1:0]              acc_f;
  logic [FW_W-igsf_pkg::FIELD_W:0]     acc_f_hi;
  logic [igsf_pkg::FIELD_W-1:0]        sat_f;
  logic signed [igsf_pkg::ENERGY_W-1:0] energy_q;
  logic signed [igsf_pkg::FIELD_W-1:0]  field_q;
  logic                                 flipped_q;
  logic signed [UPD_W-1:0]             fld_x2, upd;
  logic [igsf_pkg::ENERGY_W-1:0]       upd_sat;

  always_comb begin
    acc_e    = EW_W'(acc_q);
    acc_e_hi = acc_e[EW_W-1:igsf_pkg::ENERGY_W-1];
    if ((&acc_e_hi) || !(|acc_e_hi)) begin
      sat_e = acc_e[igsf_pkg::ENERGY_W-1:0];
    end else begin
      sat_e = acc_e[EW_W-1] ? E_MIN : E_MAX;
    end
    acc_f    = FW_W'(acc_q);
    acc_f_hi = acc_f[FW_W-1:igsf_pkg::FIELD_W-1];
    if ((&acc_f_hi) || !(|acc_f_hi)) begin
      sat_f = acc_f[igsf_pkg::FIELD_W-1:0];
    end else begin
      sat_f = acc_f[FW_W-1] ? F_MIN : F_MAX;
    end
    fld_x2 = UPD_W'(field_q) <<< 1;
    upd    = si_q ? (UPD_W'(energy_q) + fld_x2) : (UPD_W'(energy_q) - fld_x2);
    if (upd[UPD_W-1] == upd[UPD_W-2]) begin
      upd_sat = upd[igsf_pkg::ENERGY_W-1:0];
    end else begin
      upd_sat = upd[UPD_W-1] ? E_MIN : E_MAX;
    end
    flip_ok = si_q ? field_q[igsf_pkg::FIELD_W-1]
                   : (!field_q[igsf_pkg::FIELD_W-1] && (|field_q));
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      req_q <= in_req_i;
    end
  end

  logic           out_valid_q;
  igsf_pkg::rsp_t out_rsp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      i_q         <= '0;
      j_q         <= '0;
      p1_v_q      <= 1'b0;
      p1_diag_q   <= 1'b0;
      p1_self_q   <= 1'b0;
      site_rd_q   <= 1'b0;
      si_q        <= 1'b0;
      acc_q       <= '0;
      energy_q    <= '0;
      field_q     <= '0;
      flipped_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clr) begin
        clr_q <= clr_q + 1'b1;
      end

      if (cmd_i.take) begin
        i_q <= '0;
        j_q <= '0;
      end else if (cmd_i.sweep) begin
        if (is_eval && (j_q == LAST)) begin
          i_q <= i_q + 1'b1;
          j_q <= i_q + 1'b1;
        end else begin
          j_q <= j_q + 1'b1;
        end
      end

      p1_v_q    <= cmd_i.sweep;
      p1_diag_q <= is_eval && (i_q == j_q);
      p1_self_q <= !is_eval && (j_q == site);
      site_rd_q <= cmd_i.rd_site;

      // Spin of the tried site, or of the current row during evaluation.
      if (site_rd_q || (p1_v_q && p1_diag_q)) begin
        si_q <= spin_rd_q;
      end

      if (cmd_i.take) begin
        acc_q <= '0;
      end else if (p1_v_q) begin
        acc_q <= acc_q + term;
      end

      if (cmd_i.take) begin
        field_q   <= '0;
        flipped_q <= 1'b0;
      end else if (cmd_i.finish) begin
        if (is_eval) begin
          energy_q <= sat_e;
        end else begin
          field_q <= sat_f;
        end
      end else if (cmd_i.update && flip_ok) begin
        energy_q  <= upd_sat;
        flipped_q <= 1'b1;
      end

      if (cmd_i.reply) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.reply) begin
      out_rsp_q.energy      <= energy_q;
      out_rsp_q.local_field <= field_q;
      out_rsp_q.flipped     <= flipped_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  always_comb begin
    sts_o            = '0;
    sts_o.mode       = igsf_pkg::mode_e'(req_q.mode);
    sts_o.site_ok    = site_ok;
    sts_o.clr_last   = &clr_q;
    sts_o.sweep_last = is_eval ? ((i_q == LAST) && (j_q == LAST)) : (j_q == LAST);
    sts_o.pipe_busy  = p1_v_q;
    sts_o.out_free   = !out_valid_q || !out_stall_i;
  end

endmodule

`default_nettype wire

### hdl/ising_greedy_spin_flip.sv
// Ising spin-glass engine with greedy single-spin flips. It holds an
// upper-triangular store of signed Q8.8 pair couplings in one single-port-read
// memory, a spin memory (+1 or -1 per site) and a running energy, and answers
// every request with exactly one response carrying the energy, the local field
// of a tried site and a flip flag. A request loads a coupling, sets a spin,
// re-evaluates the full energy, or tries a flip at one site. Requests are
// served one at a time. A flip attempt reads one coupling per cycle from the
// coupling memory; a full evaluation walks the upper triangle of the coupling
// memory, one entry per cycle. After reset both memories are swept to zero,
// one entry per cycle, across the 4 ** ceil(log2(SITES)) coupling addresses
// (65536 at the default size); no request is taken during that pass.
`default_nettype none

module ising_greedy_spin_flip #(
  parameter int SITES         = igsf_pkg::SITES_DEF,
  parameter int COUPLING_BITS = igsf_pkg::COUPLING_BITS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  igsf_pkg::req_t in_req_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output igsf_pkg::rsp_t out_rsp_o
);

  // The controller sequences each request; the datapath owns the memories,
  // the sweep counters, the accumulator and the output register.
  igsf_pkg::ctl_cmd_t cmd;
  igsf_pkg::dp_sts_t  sts;

  igsf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // The response sits in a register of its own, so a new request is taken
  // while the previous response still waits downstream.
  igsf_dp #(
    .SITES         (SITES),
    .COUPLING_BITS (COUPLING_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_req_i    (in_req_i),
    .out_stall_i (out_stall_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_rsp_o   (out_rsp_o)
  );

endmodule

`default_nettype wire

### hdl/igsf_checker.sv
`default_nettype none

`include "ising_greedy_spin_flip_assert.svh"

module igsf_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_stall_i,
  input logic           out_valid_i,
  input logic           out_stall_i,
  input igsf_pkg::rsp_t out_rsp_i
);

  // A stalled response stays put.
  `IGSF_ASSERT_NEXT(a_rsp_hold, clk_i, rst_ni, out_valid_i && out_stall_i, out_valid_i && $stable(out_rsp_i))

  // Requests are served one at a time.
  `IGSF_ASSERT_NEXT(a_one_request, clk_i, rst_ni, in_valid_i && !in_stall_i, in_stall_i)

  // A flip only happens on a nonzero field.
  `IGSF_ASSERT_NOW(a_flip_field, clk_i, rst_ni, out_valid_i && out_rsp_i.flipped, out_rsp_i.local_field != '0)

  // A new response only appears while a request was being worked on.
  `IGSF_ASSERT_NOW(a_rsp_after_work, clk_i, rst_ni, $rose(out_valid_i), $past(in_stall_i))

endmodule

bind ising_greedy_spin_flip igsf_checker u_igsf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_i  (in_stall_o),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_rsp_i   (out_rsp_o)
);

`default_nettype wire
